// ----- design/ppp_pkg.sv -----
// Shared types, widths and constants for the perspective point projection core.
// Used by every module in the design folder; depends on nothing else.
package ppp_pkg;

    // Field and datapath widths
    localparam int COORD_W    = 24;              // Q16.8 world coordinate
    localparam int REL_W      = COORD_W + 1;     // point minus camera
    localparam int VEC_W      = 16;              // Q1.14 basis component
    localparam int VEC3_W     = 3 * VEC_W;       // packed basis vector
    localparam int PROD_W     = REL_W + VEC_W;   // one term of a dot product
    localparam int DOT_W      = PROD_W + 2;      // sum of three terms, Q.22
    localparam int SCALE_W    = 16;
    localparam int Q4_SHIFT   = 4;
    localparam int SC_W       = SCALE_W + Q4_SHIFT;
    localparam int LO_W       = 22;              // low slice of a magnitude
    localparam int HI_W       = DOT_W - LO_W;    // high slice of a magnitude
    localparam int NUM_W      = 64;              // dividend and shifted divisor
    localparam int QUO_W      = 21;              // quotient bits kept (one per stage)
    localparam int SCR_W      = 20;              // Q16.4 screen coordinate
    localparam int FIN_W      = 24;              // final add before saturation
    localparam int CENTER_W   = 32;
    localparam int HALF_W     = CENTER_W / 2;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Near limit 0.01 in Q.22, clip marker -1000.0 in Q.4, saturation bounds
    localparam logic signed [DOT_W-1:0] NEAR_Q22  = DOT_W'(41943);
    localparam logic signed [SCR_W-1:0] CLIP_Q4   = -SCR_W'(16000);
    localparam logic signed [FIN_W-1:0] SAT_MAX   = FIN_W'(524287);
    localparam logic signed [FIN_W-1:0] SAT_MIN   = -FIN_W'(524288);

    // Reset values of the configuration registers
    localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(600);
    localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(26215000);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_UP     = 3'd4,
        REG_FWD    = 3'd5,
        REG_SCALE  = 3'd6,
        REG_CENTER = 3'd7
    } t_reg_idx;

    // Input item
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point_in;

    // Result item
    typedef struct packed {
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic                    visible;
    } t_screen_out;

    // Camera pose handed to the rotation stages
    typedef struct packed {
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic signed [COORD_W-1:0] cam_z;
        logic [VEC3_W-1:0]         right_vec;
        logic [VEC3_W-1:0]         up_vec;
        logic [VEC3_W-1:0]         fwd_vec;
    } t_cam_cfg;

    // One item as it moves through the divider stages
    typedef struct packed {
        logic             valid;
        logic             vis;
        logic             neg_x;
        logic             neg_y;
        logic             ovf_x;
        logic             ovf_y;
        logic [DOT_W-1:0] div;
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [QUO_W-1:0] quo_x;
        logic [QUO_W-1:0] quo_y;
    } t_div_item;

    // Component idx of a packed basis vector, x in the low bits
    function automatic logic signed [VEC_W-1:0] vec_comp(input logic [VEC3_W-1:0] vec,
                                                         input int idx);
        vec_comp = vec[VEC_W*idx +: VEC_W];
    endfunction

endpackage

// ----- design/ppp_rotate.sv -----
// Camera-space transform: subtract the camera position, then three dot products.
// Three register stages; depends on ppp_pkg.
module ppp_rotate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  ppp_pkg::t_point_in              i_point,
    input  ppp_pkg::t_cam_cfg               i_cfg,
    output logic                            o_valid,
    output logic signed [ppp_pkg::DOT_W-1:0] o_rx,
    output logic signed [ppp_pkg::DOT_W-1:0] o_ry,
    output logic signed [ppp_pkg::DOT_W-1:0] o_rz
);
    import ppp_pkg::*;

    logic                     r_v1, r_v2, r_v3;
    logic signed [REL_W-1:0]  r_rel  [3];
    logic signed [REL_W-1:0]  n_rel  [3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [PROD_W-1:0] n_prod [3][3];
    logic signed [DOT_W-1:0]  r_dot  [3];
    logic signed [DOT_W-1:0]  n_dot  [3];
    logic [VEC3_W-1:0]        basis  [3];

    assign basis[0] = i_cfg.right_vec;
    assign basis[1] = i_cfg.up_vec;
    assign basis[2] = i_cfg.fwd_vec;

    // Stage 1: relative position, exact in Q.8
    always_comb begin
        n_rel[0] = REL_W'(i_point.point_x) - REL_W'(i_cfg.cam_x);
        n_rel[1] = REL_W'(i_point.point_y) - REL_W'(i_cfg.cam_y);
        n_rel[2] = REL_W'(i_point.point_z) - REL_W'(i_cfg.cam_z);
    end

    // Stage 2: nine independent products, one per axis and component
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[a][c] = r_rel[c] * vec_comp(basis[a], c);
            end
        end
    end

    // Stage 3: sum the three terms of each axis, Q.22
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_dot[a] = DOT_W'(r_prod[a][0]) + DOT_W'(r_prod[a][1]) + DOT_W'(r_prod[a][2]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rel  <= n_rel;
            r_prod <= n_prod;
            r_dot  <= n_dot;
        end
    end

    assign o_valid = r_v3;
    assign o_rx    = r_dot[0];
    assign o_ry    = r_dot[1];
    assign o_rz    = r_dot[2];

endmodule

// ----- design/ppp_scale.sv -----
// Near test, magnitudes, scaling by proj_scale*16 and divider setup.
// Four register stages; depends on ppp_pkg.
module ppp_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [ppp_pkg::DOT_W-1:0]  i_rx,
    input  logic signed [ppp_pkg::DOT_W-1:0]  i_ry,
    input  logic signed [ppp_pkg::DOT_W-1:0]  i_rz,
    input  logic [ppp_pkg::SCALE_W-1:0]       i_scale,
    output ppp_pkg::t_div_item                o_item
);
    import ppp_pkg::*;

    // Stage 4 registers: near test, sign and magnitude
    logic             r4_v, r4_vis, r4_negx, r4_negy;
    logic [DOT_W-1:0] r4_magx, r4_magy, r4_div;
    logic [DOT_W-1:0] n4_magx, n4_magy;

    // Stage 5 registers: partial products
    logic                    r5_v, r5_vis, r5_negx, r5_negy;
    logic [DOT_W-1:0]        r5_div;
    logic [LO_W+SC_W-1:0]    r5_lox, r5_loy;
    logic [HI_W+SC_W-1:0]    r5_hix, r5_hiy;
    logic [SC_W-1:0]         w_sc;

    // Stage 6 registers: full dividend
    logic             r6_v, r6_vis, r6_negx, r6_negy;
    logic [DOT_W-1:0] r6_div;
    logic [NUM_W-1:0] r6_numx, r6_numy;

    // Stage 7 register: item ready for the divider
    t_div_item        r_item, n_item;
    logic [NUM_W-1:0] w_dtop;

    // Stage 4: magnitudes; the most negative value maps to its unsigned magnitude
    always_comb begin
        n4_magx = i_rx[DOT_W-1] ? DOT_W'(-i_rx) : DOT_W'(i_rx);
        n4_magy = i_ry[DOT_W-1] ? DOT_W'(-i_ry) : DOT_W'(i_ry);
    end

    // Stage 5: split magnitude times scale in Q.4
    assign w_sc = {i_scale, Q4_SHIFT'(0)};

    // Stage 7: quotient would need more than QUO_W bits, so the result saturates
    assign w_dtop = NUM_W'(r6_div) << QUO_W;

    always_comb begin
        n_item       = '0;
        n_item.valid = r6_v;
        n_item.vis   = r6_vis;
        n_item.neg_x = r6_negx;
        n_item.neg_y = r6_negy;
        n_item.ovf_x = (r6_numx >= w_dtop);
        n_item.ovf_y = (r6_numy >= w_dtop);
        n_item.div   = r6_div;
        n_item.rem_x = r6_numx;
        n_item.rem_y = r6_numy;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v         <= 1'b0;
            r5_v         <= 1'b0;
            r6_v         <= 1'b0;
        end else if (i_en) begin
            r4_v         <= i_valid;
            r5_v         <= r4_v;
            r6_v         <= r5_v;
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_vis  <= (i_rz > NEAR_Q22);
            r4_negx <= i_rx[DOT_W-1];
            r4_negy <= i_ry[DOT_W-1];
            r4_magx <= n4_magx;
            r4_magy <= n4_magy;
            r4_div  <= DOT_W'(i_rz);

            r5_vis  <= r4_vis;
            r5_negx <= r4_negx;
            r5_negy <= r4_negy;
            r5_div  <= r4_div;
            r5_lox  <= r4_magx[LO_W-1:0] * w_sc;
            r5_loy  <= r4_magy[LO_W-1:0] * w_sc;
            r5_hix  <= r4_magx[DOT_W-1:LO_W] * w_sc;
            r5_hiy  <= r4_magy[DOT_W-1:LO_W] * w_sc;

            r6_vis  <= r5_vis;
            r6_negx <= r5_negx;
            r6_negy <= r5_negy;
            r6_div  <= r5_div;
            r6_numx <= (NUM_W'(r5_hix) << LO_W) + NUM_W'(r5_lox);
            r6_numy <= (NUM_W'(r5_hiy) << LO_W) + NUM_W'(r5_loy);
        end
    end

    // Divider entry register; only its valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- design/ppp_div_stage.sv -----
// One restoring-division stage: settles quotient bit SHIFT for x and y.
// Depends on ppp_pkg.
module ppp_div_stage #(
    parameter int unsigned SHIFT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  ppp_pkg::t_div_item i_item,
    output ppp_pkg::t_div_item o_item
);
    import ppp_pkg::*;

    t_div_item        r_item, n_item;
    logic [NUM_W-1:0] w_dsh;

    assign w_dsh = NUM_W'(i_item.div) << SHIFT;

    // Compare and subtract the shifted divisor on both axes
    always_comb begin
        n_item = i_item;
        if (i_item.rem_x >= w_dsh) begin
            n_item.rem_x        = i_item.rem_x - w_dsh;
            n_item.quo_x[SHIFT] = 1'b1;
        end
        if (i_item.rem_y >= w_dsh) begin
            n_item.rem_y        = i_item.rem_y - w_dsh;
            n_item.quo_y[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- design/perspective_point_projection_core.sv -----
// Top level of the perspective point projection core: config registers, pipeline, output.
// Depends on ppp_pkg, ppp_rotate, ppp_scale and ppp_div_stage.
//
// Projects one world point (signed Q16.8) to screen coordinates (signed Q16.4) per clock.
// A point enters every cycle while the output side keeps taking results; on its way it
// passes three stages of camera-space rotation, four of near test and
// scaling, 21 divider stages (one quotient bit each for x and y together) and one stage
// that applies the sign, adds the screen center and saturates. Points at or behind the
// near plane come out as (-1000.0, -1000.0) with visible low. A stall on a waiting result holds
// the whole pipeline; o_stall rises in the same cycle. Configuration is written through
// i_cfg_we / i_cfg_idx / i_cfg_data and must only change while no point is in flight.
module perspective_point_projection_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ppp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ppp_pkg::t_point_in                  i_point,
    output logic                                o_valid,
    input  logic                                i_stall,
    output ppp_pkg::t_screen_out                o_screen
);
    import ppp_pkg::*;

    // Configuration registers
    t_cam_cfg            r_cfg;
    logic [SCALE_W-1:0]  r_scale;
    logic [CENTER_W-1:0] r_center;

    // Pipeline links
    logic                    w_en;
    logic                    w_rot_v;
    logic signed [DOT_W-1:0] w_rx, w_ry, w_rz;
    t_div_item               w_div [QUO_W+1];
    t_div_item               w_last;

    // Final stage
    logic signed [FIN_W-1:0] w_qx, w_qy, w_offx, w_offy, w_hw, w_hh, w_sumx, w_sumy;
    logic signed [SCR_W-1:0] w_sx, w_sy;
    t_screen_out             r_out, n_out;
    logic                    r_out_valid;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= '0;
            r_scale  <= SCALE_RST;
            r_center <= CENTER_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CAM_X:  r_cfg.cam_x     <= i_cfg_data[COORD_W-1:0];
                REG_CAM_Y:  r_cfg.cam_y     <= i_cfg_data[COORD_W-1:0];
                REG_CAM_Z:  r_cfg.cam_z     <= i_cfg_data[COORD_W-1:0];
                REG_RIGHT:  r_cfg.right_vec <= i_cfg_data[VEC3_W-1:0];
                REG_UP:     r_cfg.up_vec    <= i_cfg_data[VEC3_W-1:0];
                REG_FWD:    r_cfg.fwd_vec   <= i_cfg_data[VEC3_W-1:0];
                REG_SCALE:  r_scale         <= i_cfg_data[SCALE_W-1:0];
                REG_CENTER: r_center        <= i_cfg_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances whenever the output register is empty or being taken
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    ppp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_point (i_point),
        .i_cfg   (r_cfg),
        .o_valid (w_rot_v),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_rz    (w_rz)
    );

    ppp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rot_v),
        .i_rx    (w_rx),
        .i_ry    (w_ry),
        .i_rz    (w_rz),
        .i_scale (r_scale),
        .o_item  (w_div[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        ppp_div_stage #(
            .SHIFT (QUO_W - 1 - k)
        ) u_div_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_item  (w_div[k]),
            .o_item  (w_div[k+1])
        );
    end

    assign w_last = w_div[QUO_W];

    // Sign, center offset (y flipped) and saturation
    always_comb begin
        w_qx   = FIN_W'(w_last.quo_x);
        w_qy   = FIN_W'(w_last.quo_y);
        w_offx = w_last.neg_x ? -w_qx : w_qx;
        w_offy = w_last.neg_y ? -w_qy : w_qy;
        w_hw   = FIN_W'({r_center[HALF_W-1:0], Q4_SHIFT'(0)});
        w_hh   = FIN_W'({r_center[CENTER_W-1:HALF_W], Q4_SHIFT'(0)});
        w_sumx = w_hw + w_offx;
        w_sumy = w_hh - w_offy;

        if (w_last.ovf_x) begin
            w_sx = w_last.neg_x ? SAT_MIN[SCR_W-1:0] : SAT_MAX[SCR_W-1:0];
        end else if (w_sumx > SAT_MAX) begin
            w_sx = SAT_MAX[SCR_W-1:0];
        end else if (w_sumx < SAT_MIN) begin
            w_sx = SAT_MIN[SCR_W-1:0];
        end else begin
            w_sx = w_sumx[SCR_W-1:0];
        end

        if (w_last.ovf_y) begin
            w_sy = w_last.neg_y ? SAT_MAX[SCR_W-1:0] : SAT_MIN[SCR_W-1:0];
        end else if (w_sumy > SAT_MAX) begin
            w_sy = SAT_MAX[SCR_W-1:0];
        end else if (w_sumy < SAT_MIN) begin
            w_sy = SAT_MIN[SCR_W-1:0];
        end else begin
            w_sy = w_sumy[SCR_W-1:0];
        end

        // Clipped points get the marker value
        if (w_last.vis) begin
            n_out.screen_x = w_sx;
            n_out.screen_y = w_sy;
            n_out.visible  = 1'b1;
        end else begin
            n_out.screen_x = CLIP_Q4;
            n_out.screen_y = CLIP_Q4;
            n_out.visible  = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_screen = r_out;

endmodule
